[hw/rtl/tdc_pkg.sv]
// ----------------------------------------------------------------------------
// tdc_pkg: shared types and constants of the tank drive command receiver
// Field widths, register indexes, mixing constants and the mix result type.
// ----------------------------------------------------------------------------
package tdc_pkg;

    localparam int TIMEOUT_WIDTH_DEFAULT = 20;

    localparam int MARKER_WIDTH = 8;
    localparam int TICKS_WIDTH  = 20;
    localparam int CFG_WIDTH    = 20;
    localparam int CFG_IDX_WIDTH = 1;

    localparam int BYTE_WIDTH  = 8;
    localparam int CMD_WIDTH   = 9;
    localparam int DRIVE_WIDTH = 7;
    localparam int DUTY_WIDTH  = 10;
    localparam int OUT_WIDTH   = 40;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_FRAME_MARKER   = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TIMEOUT_TICKS  = 1'b1;

    localparam logic [MARKER_WIDTH-1:0] MARKER_RESET = 8'd74;
    localparam logic [TICKS_WIDTH-1:0]  TICKS_RESET  = 20'd20000;

    localparam logic [1:0] PHASE_MARKER = 2'd0;
    localparam logic [1:0] PHASE_X      = 2'd1;
    localparam logic [1:0] PHASE_Y      = 2'd2;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic signed [CMD_WIDTH-1:0] CENTER_OFFSET = 9'sd127;

    typedef struct packed {
        logic [DRIVE_WIDTH-1:0] left_drive;
        logic [DRIVE_WIDTH-1:0] right_drive;
        logic [DUTY_WIDTH-1:0]  left_indicator_duty;
        logic [DUTY_WIDTH-1:0]  right_indicator_duty;
    } tdc_mix_t;

endpackage

[hw/rtl/tdc_mixer.sv]
// ----------------------------------------------------------------------------
// tdc_mixer: differential drive mixer
// Mixes signed x/y commands into clamped left/right drive and indicator duty.
// ----------------------------------------------------------------------------
module tdc_mixer
(
    input  logic signed [tdc_pkg::CMD_WIDTH-1:0] x_cmd,
    input  logic signed [tdc_pkg::CMD_WIDTH-1:0] y_cmd,
    output tdc_pkg::tdc_mix_t                    mix
);
    import tdc_pkg::*;

    // d*100/127 for d in 1..126 equals (d * 100 * 8257) >> 20 exactly
    localparam int MixRecip  = 825700;
    localparam int MixShift  = 20;
    localparam int ProdWidth = 27;
    localparam int MixDiv    = 127;
    localparam int DriveMax  = 100;
    localparam int DutyFull  = 1000;
    localparam int DutyStep  = 10;

    function automatic logic [DRIVE_WIDTH-1:0] scale_drive(input logic signed [9:0] d);
        logic [ProdWidth-1:0] prod;
        logic [DRIVE_WIDTH-1:0] res;
        prod = ProdWidth'(d[6:0]) * ProdWidth'(MixRecip);
        if (d <= 10'sd0)
            res = '0;
        else if (d >= 10'(MixDiv))
            res = DRIVE_WIDTH'(DriveMax);
        else
            res = prod[MixShift +: DRIVE_WIDTH];
        return res;
    endfunction

    function automatic logic [DUTY_WIDTH-1:0] duty_of(input logic [DRIVE_WIDTH-1:0] drv);
        return DUTY_WIDTH'(DutyFull) - DUTY_WIDTH'(drv) * DUTY_WIDTH'(DutyStep);
    endfunction

    logic signed [9:0] left_sum;
    logic signed [9:0] right_sum;
    logic [DRIVE_WIDTH-1:0] left_drv;
    logic [DRIVE_WIDTH-1:0] right_drv;

    assign left_sum  = 10'(x_cmd) - 10'(y_cmd);
    assign right_sum = -10'(y_cmd) - 10'(x_cmd);
    assign left_drv  = scale_drive(left_sum);
    assign right_drv = scale_drive(right_sum);

    always_comb
    begin
        mix.left_drive           = left_drv;
        mix.right_drive          = right_drv;
        mix.left_indicator_duty  = duty_of(left_drv);
        mix.right_indicator_duty = duty_of(right_drv);
    end

endmodule

[hw/rtl/tank_drive_command_receiver_core.sv]
// ----------------------------------------------------------------------------
// tank_drive_command_receiver_core: serial drive command receiver and mixer
// Parses marker/x/y frames, runs the command timeout, and mixes drive output.
// ----------------------------------------------------------------------------
// Each accepted input beat passes through the input register and then the output register.
// Throughput: one beat per cycle; the input register and the output register
// each advance whenever the stage after them is empty or being drained.
// Reset: rst_n clears the parser, commands, timeout count and beat valids,
// and loads frame_marker = 74 and command_timeout_ticks = 20000.
module tank_drive_command_receiver_core
#(
    parameter int TIMEOUT_WIDTH = tdc_pkg::TIMEOUT_WIDTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
    input  logic                                s_tuser,   // [0] mode

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [6:0] left_drive, [13:7] right_drive, [23:14] left_indicator_duty,
    // [33:24] right_indicator_duty, [34] command_live, [39:35] zero
    output logic [tdc_pkg::OUT_WIDTH-1:0]       m_tdata,

    input  logic                                cfg_we,
    input  logic [tdc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [tdc_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import tdc_pkg::*;

    logic [MARKER_WIDTH-1:0]  marker_reg;
    logic [TICKS_WIDTH-1:0]   ticks_reg;

    logic                     in_valid_reg;
    logic                     in_mode_reg;
    logic [BYTE_WIDTH-1:0]    in_byte_reg;

    logic [1:0]               phase_reg,   phase_next;
    logic [BYTE_WIDTH-1:0]    pend_x_reg,  pend_x_next;
    logic signed [CMD_WIDTH-1:0] x_cmd_reg, x_cmd_next;
    logic signed [CMD_WIDTH-1:0] y_cmd_reg, y_cmd_next;
    logic [TIMEOUT_WIDTH-1:0] count_reg,   count_next;

    logic                     out_valid_reg;
    tdc_mix_t                 out_mix_reg;
    logic                     out_live_reg;

    logic                     advance;
    tdc_mix_t                 mix;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARKER_RESET;
            ticks_reg  <= TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_MARKER:  marker_reg <= cfg_data[MARKER_WIDTH-1:0];
                REG_TIMEOUT_TICKS: ticks_reg  <= cfg_data[TICKS_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // parser and timeout update for the beat in the input register
    always_comb
    begin
        phase_next  = phase_reg;
        pend_x_next = pend_x_reg;
        x_cmd_next  = x_cmd_reg;
        y_cmd_next  = y_cmd_reg;
        count_next  = count_reg;
        if (in_mode_reg == MODE_TICK)
        begin
            if (count_reg != '0)
                count_next = count_reg - 1'b1;
        end
        else
        begin
            case (phase_reg)
                PHASE_X:
                begin
                    pend_x_next = in_byte_reg;
                    phase_next  = PHASE_Y;
                end
                PHASE_Y:
                begin
                    x_cmd_next = $signed({1'b0, pend_x_reg}) - CENTER_OFFSET;
                    y_cmd_next = $signed({1'b0, in_byte_reg}) - CENTER_OFFSET;
                    count_next = TIMEOUT_WIDTH'(ticks_reg);
                    phase_next = PHASE_MARKER;
                end
                default:
                    phase_next = (in_byte_reg == marker_reg) ? PHASE_X : PHASE_MARKER;
            endcase
        end
        // drop expired commands
        if (count_next == '0)
        begin
            x_cmd_next = '0;
            y_cmd_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PHASE_MARKER;
            pend_x_reg <= '0;
            x_cmd_reg  <= '0;
            y_cmd_reg  <= '0;
            count_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            pend_x_reg <= pend_x_next;
            x_cmd_reg  <= x_cmd_next;
            y_cmd_reg  <= y_cmd_next;
            count_reg  <= count_next;
        end
    end

    tdc_mixer u_mixer
    (
        .x_cmd (x_cmd_next),
        .y_cmd (y_cmd_next),
        .mix   (mix)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mix_reg  <= mix;
            out_live_reg <= (count_next != '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_live_reg,
                       out_mix_reg.right_indicator_duty,
                       out_mix_reg.left_indicator_duty,
                       out_mix_reg.right_drive,
                       out_mix_reg.left_drive};

`ifndef NO_ASSERTIONS
    a_expired_cmds_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (x_cmd_reg == '0 && y_cmd_reg == '0))
        else $error("expired commands not cleared");

    a_dead_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_live_reg) |->
            (out_mix_reg.left_drive == '0 && out_mix_reg.right_drive == '0))
        else $error("drive nonzero with expired commands");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline is full");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("parser in unused phase");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(m_tdata)))
        else $error("stalled result changed");
`endif

endmodule

[tb/tank_drive_command_checker.sv]
// ----------------------------------------------------------------------------
// tank_drive_command_checker: drive output predictor and comparator
// Watches the command, drive and register write ports of the receiver core,
// keeps its own copy of the frame parser, timeout and mixer, and compares
// every output beat field by field against the oldest predicted beat.
// ----------------------------------------------------------------------------
module tank_drive_command_checker
#(
    parameter int TIMEOUT_WIDTH = tdc_pkg::TIMEOUT_WIDTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] mode

    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // [6:0] left_drive, [13:7] right_drive, [23:14] left_indicator_duty,
    // [33:24] right_indicator_duty, [34] command_live, [39:35] zero
    input  logic [tdc_pkg::OUT_WIDTH-1:0]     m_tdata,

    input  logic                              cfg_we,
    input  logic [tdc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [tdc_pkg::CFG_WIDTH-1:0]     cfg_data,

    input  logic                              end_check,
    output int                                fail_count,
    output int                                beats_in,
    output int                                beats_out
);
    import tdc_pkg::*;

    localparam int MIX_GAIN   = 100;
    localparam int MIX_DIV    = 127;
    localparam int PCT_MAX    = 100;
    localparam int DUTY_FULL  = 1000;
    localparam int DUTY_STEP  = 10;

    typedef struct {
        tdc_mix_t mix;
        logic     live;
    } drive_beat_t;

    drive_beat_t drive_expected[$];

    logic [MARKER_WIDTH-1:0]  marker_reg  = MARKER_RESET;
    logic [TICKS_WIDTH-1:0]   reload_reg  = TICKS_RESET;
    logic [1:0]               phase       = PHASE_MARKER;
    logic [BYTE_WIDTH-1:0]    held_x      = '0;
    int                       x_cmd       = 0;
    int                       y_cmd       = 0;
    logic [TIMEOUT_WIDTH-1:0] countdown   = '0;

    int  mismatches = 0;
    bit  end_done   = 1'b0;

    assign fail_count = mismatches;

    task automatic report(input string msg);
        $display("mismatch at drive beat %0d: %s", beats_out, msg);
        mismatches++;
    endtask

    function automatic int clamp_pct(input int v);
        if (v > PCT_MAX)
            return PCT_MAX;
        if (v < 0)
            return 0;
        return v;
    endfunction

    // Advance the parser and timeout by one command beat, then mix.
    task automatic predict_drive(input logic mode, input logic [BYTE_WIDTH-1:0] rx);
        drive_beat_t beat;
        int          lpct;
        int          rpct;
        if (mode == MODE_TICK)
        begin
            if (countdown != 0)
                countdown = countdown - 1'b1;
        end
        else
        begin
            case (phase)
                PHASE_X:
                begin
                    held_x = rx;
                    phase  = PHASE_Y;
                end
                PHASE_Y:
                begin
                    x_cmd     = int'(held_x) - int'(CENTER_OFFSET);
                    y_cmd     = int'(rx) - int'(CENTER_OFFSET);
                    countdown = TIMEOUT_WIDTH'(reload_reg);
                    phase     = PHASE_MARKER;
                end
                default:
                    phase = (rx == marker_reg) ? PHASE_X : PHASE_MARKER;
            endcase
        end

        // Expired commands read as zero.
        if (countdown == 0)
        begin
            x_cmd = 0;
            y_cmd = 0;
        end

        lpct = clamp_pct(((x_cmd - y_cmd) * MIX_GAIN) / MIX_DIV);
        rpct = clamp_pct(((-y_cmd - x_cmd) * MIX_GAIN) / MIX_DIV);

        beat.mix.left_drive           = DRIVE_WIDTH'(lpct);
        beat.mix.right_drive          = DRIVE_WIDTH'(rpct);
        beat.mix.left_indicator_duty  = DUTY_WIDTH'(DUTY_FULL - DUTY_STEP * lpct);
        beat.mix.right_indicator_duty = DUTY_WIDTH'(DUTY_FULL - DUTY_STEP * rpct);
        beat.live                     = (countdown != 0);
        drive_expected.push_back(beat);
    endtask

    task automatic compare_drive(input logic [OUT_WIDTH-1:0] got);
        drive_beat_t want;
        if (drive_expected.size() == 0)
        begin
            report($sformatf("unexpected beat, tdata 0x%010h", got));
            return;
        end
        want = drive_expected.pop_front();
        if (got[6:0] !== want.mix.left_drive)
            report($sformatf("left_drive %0d, want %0d", got[6:0], want.mix.left_drive));
        if (got[13:7] !== want.mix.right_drive)
            report($sformatf("right_drive %0d, want %0d", got[13:7], want.mix.right_drive));
        if (got[23:14] !== want.mix.left_indicator_duty)
            report($sformatf("left_indicator_duty %0d, want %0d",
                             got[23:14], want.mix.left_indicator_duty));
        if (got[33:24] !== want.mix.right_indicator_duty)
            report($sformatf("right_indicator_duty %0d, want %0d",
                             got[33:24], want.mix.right_indicator_duty));
        if (got[34] !== want.live)
            report($sformatf("command_live %0d, want %0d", got[34], want.live));
        if (got[39:35] !== 5'd0)
            report($sformatf("pad bits 0x%02h, want zero", got[39:35]));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg = MARKER_RESET;
            reload_reg = TICKS_RESET;
            phase      = PHASE_MARKER;
            held_x     = '0;
            x_cmd      = 0;
            y_cmd      = 0;
            countdown  = '0;
            drive_expected.delete();
            beats_in  <= 0;
            beats_out <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_MARKER:  marker_reg = cfg_data[MARKER_WIDTH-1:0];
                    REG_TIMEOUT_TICKS: reload_reg = cfg_data[TICKS_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                predict_drive(s_tuser, s_tdata);
                beats_in <= beats_in + 1;
            end
            if (m_tvalid && m_tready)
            begin
                compare_drive(m_tdata);
                beats_out <= beats_out + 1;
            end
            if (end_check && !end_done)
            begin
                end_done = 1'b1;
                if (drive_expected.size() != 0)
                    report($sformatf("%0d predicted beats never arrived",
                                     drive_expected.size()));
            end
        end
    end

endmodule

[tb/tank_drive_command_receiver_core_test.sv]
// ----------------------------------------------------------------------------
// tank_drive_command_receiver_core_test: stimulus and verdict for the receiver
// Drives directed and random command beats (bytes, frames, ticks) through
// several register settings with random stalls on both sides, and lets the
// checker predict and compare every drive beat.
// ----------------------------------------------------------------------------
module tank_drive_command_receiver_core_test;

    import tdc_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int PHASE_COUNT  = 6;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [7:0]               s_tdata   = '0;
    logic                     s_tuser   = MODE_BYTE;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_WIDTH-1:0]     m_tdata;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = REG_FRAME_MARKER;
    logic [CFG_WIDTH-1:0]     cfg_data  = '0;
    logic                     end_check = 1'b0;

    int fail_count;
    int beats_in;
    int beats_out;

    bit                    no_idle       = 1'b0;
    bit                    rx_hold_req   = 1'b0;
    int                    beats_sent    = 0;
    int                    settings_used = 0;
    int                    idle_cycles   = 0;
    logic [MARKER_WIDTH-1:0] marker_now  = MARKER_RESET;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tank_drive_command_receiver_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tank_drive_command_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .end_check  (end_check),
        .fail_count (fail_count),
        .beats_in   (beats_in),
        .beats_out  (beats_out)
    );

    // Drop the watchdog on any cycle that moves a beat.
    always @(posedge clk)
    begin
        if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("stalled for %0d cycles with no beat moving", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Drive sink: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic send_beat(input logic mode, input logic [7:0] rx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_tick();
        send_beat(MODE_TICK, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_beat(MODE_BYTE, rx);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (beats_in != beats_out);
    endtask

    task automatic load_setting(input logic [7:0] marker, input logic [19:0] ticks);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_MARKER;
        cfg_data  <= CFG_WIDTH'(marker);
        @(posedge clk);
        cfg_index <= REG_TIMEOUT_TICKS;
        cfg_data  <= CFG_WIDTH'(ticks);
        @(posedge clk);
        cfg_we    <= 1'b0;
        marker_now = marker;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return marker_now;
            default: return 8'($urandom);
        endcase
    endfunction

    // Frame with random content; ticks may land between its bytes.
    task automatic send_frame(input int tick_pct);
        send_byte(marker_now);
        if ($urandom_range(0, 99) < tick_pct)
            send_tick();
        send_byte(pick_byte());
        if ($urandom_range(0, 99) < tick_pct)
            send_tick();
        send_byte(pick_byte());
    endtask

    initial
    begin
        int          phase_end;
        int          kind;
        int          half;
        logic [7:0]  rnd_marker;
        logic [19:0] rnd_ticks;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: marker 74, long timeout.
        settings_used = 1;
        send_tick();                      // tick while expired
        send_byte(8'd0);                  // idle byte, dropped
        send_byte(8'd74);                 // full left
        send_byte(8'd255);
        send_byte(8'd0);
        send_byte(8'd74);                 // full right
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'd74);                 // marker bytes taken as data
        send_byte(8'd74);
        send_byte(8'd74);
        send_byte(8'd74);                 // ticks in the middle of a frame
        send_tick();
        send_byte(8'd177);
        send_tick();
        send_byte(8'd127);

        // Zero reload: commands expire as soon as they land.
        load_setting(8'd74, 20'd0);
        send_byte(8'd74);
        send_byte(8'd77);
        send_byte(8'd127);

        // Short timeout that runs out after two ticks.
        load_setting(8'd255, 20'd2);
        send_byte(8'd255);
        send_byte(8'd0);
        send_byte(8'd0);
        send_tick();
        send_tick();

        // Zero marker and the widest reload.
        load_setting(8'd0, 20'hFFFFF);
        send_byte(8'd0);
        send_byte(8'd200);
        send_byte(8'd54);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            rnd_marker = 8'($urandom);
            case (p)
                0: load_setting(rnd_marker, 20'($urandom_range(1, 12)));
                1: load_setting(8'd0, 20'd0);
                2: load_setting(8'd255, 20'hFFFFF);
                3: load_setting(rnd_marker, 20'($urandom_range(1, 40)));
                4: load_setting(MARKER_RESET, TICKS_RESET);
                default:
                begin
                    rnd_ticks = 20'($urandom);
                    load_setting(rnd_marker,
                                 (rnd_ticks[0]) ? rnd_ticks : 20'($urandom_range(1, 6)));
                end
            endcase
            phase_end = beats_sent + PHASE_ITEMS;
            half      = beats_sent + PHASE_ITEMS / 2;
            while (beats_sent < phase_end)
            begin
                if (beats_sent % 50 < 4)
                    no_idle = ($urandom_range(0, 3) == 0);
                // Long output hold-off in one phase, full drain in another.
                if (p == 2 && beats_sent >= half)
                begin
                    rx_hold_req = 1'b1;
                    half = phase_end;
                end
                if (p == 3 && beats_sent >= half)
                begin
                    drain_results();
                    half = phase_end;
                end
                kind = $urandom_range(0, 9);
                if (kind <= 5)
                    send_frame(25);
                else if (kind <= 7)
                    repeat ($urandom_range(1, 4)) send_tick();
                else if (kind == 8)
                    send_byte(8'($urandom));
                else
                begin
                    // Broken frame: marker and one byte only.
                    send_byte(marker_now);
                    send_byte(pick_byte());
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        end_check <= 1'b1;
        repeat (2) @(posedge clk);

        $display("covered %0d command beats and %0d drive beats over %0d register settings,",
                 beats_in, beats_out, settings_used);
        $display("with random stalls, one long output hold-off and a mid-stream drain");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tdc_pkg.sv
hw/rtl/tdc_mixer.sv
hw/rtl/tank_drive_command_receiver_core.sv
tb/tank_drive_command_checker.sv
tb/tank_drive_command_receiver_core_test.sv
